// File: hw/rtl/pwmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Peer wire deframer package
// Shared constants, codes and the beat types passed between the parser front,
// the operation queue and the map engine.
// ----------------------------------------------------------------------------
package pwmd_pkg;

    // Map geometry
    localparam int MAX_PIECES = 4096;
    localparam int PIECE_W    = $clog2(MAX_PIECES);
    localparam int COUNT_W    = PIECE_W + 1;
    localparam int MAP_DEPTH  = MAX_PIECES / 8;
    localparam int MAP_AW     = $clog2(MAP_DEPTH);
    localparam int BIT_W      = PIECE_W - MAP_AW;
    localparam int POS_W      = MAP_AW + 1;

    // Framing
    localparam int LEN_W          = 32;
    localparam int HDR_W          = 3;
    localparam int HAVE_IDX_BYTES = 4;
    localparam int HAVE_MSG_LEN   = HAVE_IDX_BYTES + 1;

    // Queue depths
    localparam int OPQ_DEPTH = 2;
    localparam int OPQ_AW    = $clog2(OPQ_DEPTH);
    localparam int RQ_DEPTH  = 2;
    localparam int RQ_AW     = $clog2(RQ_DEPTH);

    // Message ids
    localparam logic [7:0] MSG_CHOKE          = 8'd0;
    localparam logic [7:0] MSG_UNCHOKE        = 8'd1;
    localparam logic [7:0] MSG_INTERESTED     = 8'd2;
    localparam logic [7:0] MSG_NOT_INTERESTED = 8'd3;
    localparam logic [7:0] MSG_HAVE           = 8'd4;
    localparam logic [7:0] MSG_BITFIELD       = 8'd5;
    localparam logic [7:0] MSG_REQUEST        = 8'd6;
    localparam logic [7:0] MSG_PIECE          = 8'd7;
    localparam logic [7:0] MSG_CANCEL         = 8'd8;
    localparam logic [7:0] MSG_PORT           = 8'd9;

    typedef enum logic [1:0] {
        PH_LEN     = 2'd0,
        PH_ID      = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_SPARE   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_FINISH = 2'd0,
        KIND_AVAIL  = 2'd1,
        KIND_QUERY  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_KEEPALIVE = 2'd1,
        ST_BAD_ID    = 2'd2,
        ST_REPEAT_BF = 2'd3
    } t_status;

    // One classified item for the map engine
    typedef struct packed {
        logic              is_query;
        logic [BIT_W-1:0]  q_bit;
        logic              map_en;
        logic [MAP_AW-1:0] addr;
        logic [7:0]        mask;
        logic              fin_en;
        logic [7:0]        fin_id;
        t_status           fin_st;
        logic              choke;
        logic              interest;
    } t_op;

    // One result beat
    typedef struct packed {
        t_kind              kind;
        logic [7:0]         message_id;
        t_status            status;
        logic [PIECE_W-1:0] avail_base;
        logic [7:0]         avail_mask;
        logic               piece_available;
        logic               choke;
        logic               interest;
        logic               last;
    } t_res;

endpackage
`default_nettype wire

// File: hw/rtl/peer_wire_message_deframer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Peer wire message deframer core
// Splits the post-handshake peer wire stream into messages, tracks the peer
// flags and keeps a piece availability map that can be queried.
// ----------------------------------------------------------------------------
// Usage: one beat on the input side is either a stream byte (i_cmd low) or a
// map query (i_cmd high). The core takes one beat per clock while full is
// low. Every beat is classified in the parser front in the cycle it is taken;
// queries, map updates and message finishes go through a two-entry operation
// queue to the map engine, which performs one byte-wide read-modify-write of
// the 512 x 8 map per cycle while its two-entry result queue has room (the
// byte is read into a register, then modified and written, with forwarding
// between neighbouring beats). A beat gives at most one result per cycle of
// the map engine, so a message finish that also reports newly available
// pieces (a have, or a last bitfield byte) holds the engine until both of
// its results are queued. After reset the map is cleared by a sweep of all
// 512 bytes during which full stays high; piece_count writes are taken at
// any time but should only be made while the core is idle.
// ----------------------------------------------------------------------------
module peer_wire_message_deframer_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input side
    input  logic                         push,
    output logic                         full,
    input  logic                         i_cmd,
    input  logic [7:0]                   i_rx_byte,
    input  logic [pwmd_pkg::PIECE_W-1:0] i_query_index,
    // result side
    output logic                         empty,
    input  logic                         pop,
    output logic [1:0]                   o_kind,
    output logic [7:0]                   o_message_id,
    output logic [1:0]                   o_msg_status,
    output logic [pwmd_pkg::PIECE_W-1:0] o_avail_base,
    output logic [7:0]                   o_avail_mask,
    output logic                         o_piece_available,
    output logic                         o_peer_choking_now,
    output logic                         o_peer_interested_now,
    output logic                         o_last,
    // configuration
    input  logic                         i_cfg_we,
    input  logic [pwmd_pkg::COUNT_W-1:0] i_cfg_wdata
);
    import pwmd_pkg::*;

    logic [COUNT_W-1:0] r_piece_count;

    logic accept;
    logic op_valid;
    t_op  op_in;
    t_op  op_head;
    logic opq_full;
    logic opq_empty;
    logic op_pop;
    logic clearing;
    t_res res;

    // Hold the input side while the map sweep runs or the queue has no room
    assign full   = opq_full || clearing;
    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_piece_count <= '0;
        end else if (i_cfg_we) begin
            r_piece_count <= i_cfg_wdata;
        end
    end

    // Frame, track flags and classify each beat
    pwmd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_cmd         (i_cmd),
        .i_rx_byte     (i_rx_byte),
        .i_query_index (i_query_index),
        .i_piece_count (r_piece_count),
        .o_op_valid    (op_valid),
        .o_op          (op_in)
    );

    // Decouple the front from the map engine
    pwmd_opq u_opq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_valid),
        .i_op    (op_in),
        .o_full  (opq_full),
        .i_pop   (op_pop),
        .o_empty (opq_empty),
        .o_op    (op_head)
    );

    // Map read-modify-write and result beats
    pwmd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (!opq_empty),
        .i_op       (op_head),
        .o_op_pop   (op_pop),
        .o_clearing (clearing),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_res      (res)
    );

    assign o_kind                = res.kind;
    assign o_message_id          = res.message_id;
    assign o_msg_status          = res.status;
    assign o_avail_base          = res.avail_base;
    assign o_avail_mask          = res.avail_mask;
    assign o_piece_available     = res.piece_available;
    assign o_peer_choking_now    = res.choke;
    assign o_peer_interested_now = res.interest;
    assign o_last                = res.last;

endmodule
`default_nettype wire

// File: hw/rtl/pwmd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Peer wire deframer: parser front
// Frames the byte stream, keeps the peer flags and classifies each accepted
// beat into at most one map engine operation.
// ----------------------------------------------------------------------------
module pwmd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic                         i_cmd,
    input  logic [7:0]                   i_rx_byte,
    input  logic [pwmd_pkg::PIECE_W-1:0] i_query_index,
    input  logic [pwmd_pkg::COUNT_W-1:0] i_piece_count,
    output logic                         o_op_valid,
    output pwmd_pkg::t_op                o_op
);
    import pwmd_pkg::*;

    t_phase             r_phase, n_phase;
    logic [HDR_W-1:0]   r_hc, n_hc;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [7:0]         r_id, n_id;
    logic [LEN_W-1:0]   r_left, n_left;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [LEN_W-1:0]   r_acc, n_acc;
    logic               r_choke, n_choke;
    logic               r_interest, n_interest;
    logic               r_seen, n_seen;

    logic [COUNT_W-1:0] lim;
    logic [7:0]         bf_mask;
    logic               fin;
    t_op                op;

    always_comb begin
        lim = (i_piece_count > COUNT_W'(MAX_PIECES)) ? COUNT_W'(MAX_PIECES) : i_piece_count;
        // MSB of the byte is the lowest piece of its group
        for (int k = 0; k < 8; k++) begin
            bf_mask[k] = i_rx_byte[7-k] &&
                         (COUNT_W'({r_pos[MAP_AW-1:0], BIT_W'(k)}) < lim);
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_hc       = r_hc;
        n_len      = r_len;
        n_id       = r_id;
        n_left     = r_left;
        n_pos      = r_pos;
        n_acc      = r_acc;
        n_choke    = r_choke;
        n_interest = r_interest;
        n_seen     = r_seen;
        fin        = 1'b0;
        op         = '0;
        op.fin_st  = ST_OK;

        if (i_accept) begin
            if (i_cmd) begin
                op.is_query = 1'b1;
                op.addr     = i_query_index[PIECE_W-1:BIT_W];
                op.q_bit    = i_query_index[BIT_W-1:0];
            end else begin
                unique case (r_phase) inside
                    PH_ID: begin
                        n_id   = i_rx_byte;
                        n_left = r_len - LEN_W'(1);
                        n_pos  = '0;
                        n_acc  = '0;
                        if (r_len == LEN_W'(1)) begin
                            fin = 1'b1;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        if (r_id == MSG_BITFIELD && !r_pos[POS_W-1]) begin
                            op.map_en = |bf_mask;
                            op.addr   = r_pos[MAP_AW-1:0];
                            op.mask   = bf_mask;
                        end
                        if (r_id == MSG_HAVE && r_pos < POS_W'(HAVE_IDX_BYTES)) begin
                            n_acc = {r_acc[LEN_W-9:0], i_rx_byte};
                        end
                        // saturate once past the end of the map
                        if (!r_pos[POS_W-1]) begin
                            n_pos = r_pos + POS_W'(1);
                        end
                        n_left = r_left - LEN_W'(1);
                        if (r_left == LEN_W'(1)) begin
                            fin = 1'b1;
                        end
                    end
                    PH_LEN, PH_SPARE: begin
                        n_phase = PH_LEN;
                        n_len   = {r_len[LEN_W-9:0], i_rx_byte};
                        n_hc    = r_hc + HDR_W'(1);
                        if (n_hc[HDR_W-1]) begin
                            n_hc = '0;
                            if (n_len == '0) begin
                                op.fin_en = 1'b1;
                                op.fin_id = MSG_CHOKE;
                                op.fin_st = ST_KEEPALIVE;
                            end else begin
                                n_phase = PH_ID;
                            end
                        end
                    end
                endcase
            end

            if (fin) begin
                op.fin_en = 1'b1;
                op.fin_id = n_id;
                n_phase   = PH_LEN;
                unique case (n_id) inside
                    MSG_CHOKE:          n_choke = 1'b1;
                    MSG_UNCHOKE:        n_choke = 1'b0;
                    MSG_INTERESTED:     n_interest = 1'b1;
                    MSG_NOT_INTERESTED: n_interest = 1'b0;
                    MSG_HAVE: begin
                        if (r_len == LEN_W'(HAVE_MSG_LEN) &&
                            n_acc[LEN_W-1:COUNT_W] == '0 &&
                            n_acc[COUNT_W-1:0] < lim) begin
                            op.map_en = 1'b1;
                            op.addr   = n_acc[PIECE_W-1:BIT_W];
                            op.mask   = 8'b1 << n_acc[BIT_W-1:0];
                        end
                    end
                    MSG_BITFIELD: begin
                        op.fin_st = r_seen ? ST_REPEAT_BF : ST_OK;
                        n_seen    = 1'b1;
                    end
                    MSG_REQUEST, MSG_PIECE, MSG_CANCEL, MSG_PORT: ;
                    default: op.fin_st = ST_BAD_ID;
                endcase
            end
        end

        op.choke    = n_choke;
        op.interest = n_interest;
    end

    assign o_op       = op;
    assign o_op_valid = i_accept && (i_cmd || op.map_en || op.fin_en);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_LEN;
            r_hc       <= '0;
            r_len      <= '0;
            r_id       <= '0;
            r_left     <= '0;
            r_pos      <= '0;
            r_acc      <= '0;
            r_choke    <= 1'b1;
            r_interest <= 1'b0;
            r_seen     <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_hc       <= n_hc;
            r_len      <= n_len;
            r_id       <= n_id;
            r_left     <= n_left;
            r_pos      <= n_pos;
            r_acc      <= n_acc;
            r_choke    <= n_choke;
            r_interest <= n_interest;
            r_seen     <= n_seen;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/pwmd_opq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Peer wire deframer: operation queue
// Short queue that decouples the parser front from the map engine.
// ----------------------------------------------------------------------------
module pwmd_opq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pwmd_pkg::t_op i_op,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output pwmd_pkg::t_op o_op
);
    import pwmd_pkg::*;

    t_op               r_slot [OPQ_DEPTH];
    logic [OPQ_AW-1:0] r_wr_ptr;
    logic [OPQ_AW-1:0] r_rd_ptr;
    logic [OPQ_AW:0]   r_count;

    assign o_full  = (r_count == (OPQ_AW+1)'(OPQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_op    = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + OPQ_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + OPQ_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (OPQ_AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (OPQ_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/pwmd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Peer wire deframer: map engine
// Holds the piece map memory, runs the read-modify-write for each operation,
// builds result beats and keeps them in a small result queue.
// ----------------------------------------------------------------------------
module pwmd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_op_valid,
    input  pwmd_pkg::t_op  i_op,
    output logic           o_op_pop,
    output logic           o_clearing,
    input  logic           i_pop,
    output logic           o_empty,
    output pwmd_pkg::t_res o_res
);
    import pwmd_pkg::*;

    logic [7:0]        r_map [MAP_DEPTH];
    logic              r_clearing;
    logic [MAP_AW-1:0] r_clr_addr;

    logic [7:0]        r_rd_data;
    logic [7:0]        r_fwd_data;
    logic              r_fwd_hit;
    logic              r_s2_v;
    logic              r_half, n_half;
    t_op               r_s2_op;

    t_res              r_rq [RQ_DEPTH];
    logic [RQ_AW-1:0]  r_rq_wr;
    logic [RQ_AW-1:0]  r_rq_rd;
    logic [RQ_AW:0]    r_rq_count;

    logic              wr_en;
    logic [MAP_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [7:0]        cur;
    logic [7:0]        new_bits;
    logic              act;
    logic              s2_done;
    logic              s1_go;
    logic              rq_push;
    logic              rq_pop;
    t_res              res;

    always_comb begin
        // take the write that landed on the same edge as our read
        cur      = r_fwd_hit ? r_fwd_data : r_rd_data;
        new_bits = r_s2_op.mask & ~cur;
        act      = r_s2_v && (r_rq_count != (RQ_AW+1)'(RQ_DEPTH));

        res          = '0;
        res.kind     = KIND_FINISH;
        res.status   = ST_OK;
        res.choke    = r_s2_op.choke;
        res.interest = r_s2_op.interest;
        res.last     = 1'b1;

        rq_push = 1'b0;
        s2_done = 1'b0;
        n_half  = r_half;
        wr_en   = r_clearing;
        wr_addr = r_clr_addr;
        wr_data = '0;

        if (act) begin
            if (r_s2_op.is_query) begin
                res.kind            = KIND_QUERY;
                res.piece_available = cur[r_s2_op.q_bit];
                rq_push             = 1'b1;
                s2_done             = 1'b1;
            end else if (r_s2_op.map_en && !r_half) begin
                wr_en   = 1'b1;
                wr_addr = r_s2_op.addr;
                wr_data = cur | r_s2_op.mask;
                if (new_bits != '0) begin
                    res.kind       = KIND_AVAIL;
                    res.avail_base = {r_s2_op.addr, {BIT_W{1'b0}}};
                    res.avail_mask = new_bits;
                    res.last       = !r_s2_op.fin_en;
                    rq_push        = 1'b1;
                    n_half         = r_s2_op.fin_en;
                    s2_done        = !r_s2_op.fin_en;
                end else if (r_s2_op.fin_en) begin
                    res.message_id = r_s2_op.fin_id;
                    res.status     = r_s2_op.fin_st;
                    rq_push        = 1'b1;
                    s2_done        = 1'b1;
                end else begin
                    s2_done = 1'b1;
                end
            end else begin
                res.message_id = r_s2_op.fin_id;
                res.status     = r_s2_op.fin_st;
                rq_push        = 1'b1;
                s2_done        = 1'b1;
            end
        end

        if (s2_done) begin
            n_half = 1'b0;
        end

        s1_go = i_op_valid && !r_clearing && (!r_s2_v || s2_done);
    end

    assign rq_pop     = i_pop && (r_rq_count != '0);
    assign o_empty    = (r_rq_count == '0);
    assign o_res      = r_rq[r_rq_rd];
    assign o_op_pop   = s1_go;
    assign o_clearing = r_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_s2_v     <= 1'b0;
            r_half     <= 1'b0;
            r_rq_wr    <= '0;
            r_rq_rd    <= '0;
            r_rq_count <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + MAP_AW'(1);
                if (r_clr_addr == MAP_AW'(MAP_DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (s1_go) begin
                r_s2_v <= 1'b1;
            end else if (s2_done) begin
                r_s2_v <= 1'b0;
            end
            r_half <= n_half;
            if (rq_push) begin
                r_rq_wr <= r_rq_wr + RQ_AW'(1);
            end
            if (rq_pop) begin
                r_rq_rd <= r_rq_rd + RQ_AW'(1);
            end
            if (rq_push && !rq_pop) begin
                r_rq_count <= r_rq_count + (RQ_AW+1)'(1);
            end else if (!rq_push && rq_pop) begin
                r_rq_count <= r_rq_count - (RQ_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map[wr_addr] <= wr_data;
        end
        if (s1_go) begin
            r_rd_data  <= r_map[i_op.addr];
            r_fwd_hit  <= wr_en && (wr_addr == i_op.addr);
            r_fwd_data <= wr_data;
            r_s2_op    <= i_op;
        end
        if (rq_push) begin
            r_rq[r_rq_wr] <= res;
        end
    end

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peer wire message deframer core testbench
// Drives framed peer wire streams and map queries into the core, with bursty
// input and a stalling result side. A beat-level software copy of the
// deframer, its peer flags and its piece map works out each result beat,
// which is then compared field by field as the core delivers it.
// ----------------------------------------------------------------------------
module testbench;

    import pwmd_pkg::*;

    localparam int          CLK_PERIOD  = 10;
    localparam int          RESET_TICKS = 11;
    // Allow the queues to settle well after the last result before touching the
    // register or finishing.
    localparam int          IDLE_TAIL   = 16;
    localparam int unsigned CYCLE_LIMIT = 500_000;
    localparam int          MAP_BYTES   = MAX_PIECES / 8;

    // ------------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------------
    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic               i_cmd;
    logic [7:0]         i_rx_byte;
    logic [PIECE_W-1:0] i_query_index;
    logic               empty;
    logic               pop = 1'b0;
    logic [1:0]         o_kind;
    logic [7:0]         o_message_id;
    logic [1:0]         o_msg_status;
    logic [PIECE_W-1:0] o_avail_base;
    logic [7:0]         o_avail_mask;
    logic               o_piece_available;
    logic               o_peer_choking_now;
    logic               o_peer_interested_now;
    logic               o_last;
    logic               i_cfg_we;
    logic [COUNT_W-1:0] i_cfg_wdata;

    peer_wire_message_deframer_core dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .push                  (push),
        .full                  (full),
        .i_cmd                 (i_cmd),
        .i_rx_byte             (i_rx_byte),
        .i_query_index         (i_query_index),
        .empty                 (empty),
        .pop                   (pop),
        .o_kind                (o_kind),
        .o_message_id          (o_message_id),
        .o_msg_status          (o_msg_status),
        .o_avail_base          (o_avail_base),
        .o_avail_mask          (o_avail_mask),
        .o_piece_available     (o_piece_available),
        .o_peer_choking_now    (o_peer_choking_now),
        .o_peer_interested_now (o_peer_interested_now),
        .o_last                (o_last),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_wdata           (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Software deframer: its own copy of the parser state, flags and map
    // ------------------------------------------------------------------------
    logic [COUNT_W-1:0] piece_count     = '0;
    t_phase             stream_phase    = PH_LEN;
    logic [2:0]         header_bytes    = '0;
    logic [31:0]        length_word     = '0;
    logic [7:0]         message_id      = '0;
    logic [31:0]        payload_left    = '0;
    logic [31:0]        payload_pos     = '0;
    logic [31:0]        have_index      = '0;
    logic               choke_flag      = 1'b1;
    logic               interest_flag   = 1'b0;
    logic               bitfield_seen   = 1'b0;
    logic               known_pieces [MAX_PIECES];

    t_res        beat_reports[$];     // reports caused by the beat in hand
    t_res        pending_reports[$];  // reports still owed by the core

    int unsigned error_count = 0;
    int unsigned beats_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned query_pct   = 0;
    int unsigned cycle_count = 0;
    logic [8:0]  stall_step  = '0;
    logic [7:0]  frame[$];
    logic [7:0]  payload[$];

    // Map indices are valid below both the register and the map size
    function automatic logic [31:0] piece_bound();
        return (32'(piece_count) < 32'(MAX_PIECES)) ? 32'(piece_count) : 32'(MAX_PIECES);
    endfunction

    // Flags are stamped as they stand when the report is made
    function automatic t_res make_report(t_kind kind, logic [7:0] id, t_status status,
                                         logic [PIECE_W-1:0] base, logic [7:0] mask,
                                         logic avail);
        t_res r;
        r.kind            = kind;
        r.message_id      = id;
        r.status          = status;
        r.avail_base      = base;
        r.avail_mask      = mask;
        r.piece_available = avail;
        r.choke           = choke_flag;
        r.interest        = interest_flag;
        r.last            = 1'b0;
        return r;
    endfunction

    // Append a report to those of the beat in hand
    task automatic add_report(input t_res r);
        beat_reports.insert(beat_reports.size(), r);
    endtask

    // Append one byte to the frame being built
    task automatic add_byte(input logic [7:0] b);
        frame.insert(frame.size(), b);
    endtask

    // Act on the id of a message whose last byte has just arrived
    task automatic close_message();
        t_status status;
        status = ST_OK;
        case (message_id)
            MSG_CHOKE:          choke_flag    = 1'b1;
            MSG_UNCHOKE:        choke_flag    = 1'b0;
            MSG_INTERESTED:     interest_flag = 1'b1;
            MSG_NOT_INTERESTED: interest_flag = 1'b0;
            MSG_HAVE: begin
                // Only a well-sized have naming a new piece in range counts
                if (length_word == HAVE_MSG_LEN && have_index < piece_bound()
                        && !known_pieces[have_index[PIECE_W-1:0]]) begin
                    known_pieces[have_index[PIECE_W-1:0]] = 1'b1;
                    add_report(make_report(KIND_AVAIL, 8'd0, ST_OK,
                        {have_index[PIECE_W-1:3], 3'b000},
                        8'd1 << have_index[2:0], 1'b0));
                end
            end
            MSG_BITFIELD: begin
                status        = bitfield_seen ? ST_REPEAT_BF : ST_OK;
                bitfield_seen = 1'b1;
            end
            MSG_REQUEST, MSG_PIECE, MSG_CANCEL, MSG_PORT: ;
            default: status = ST_BAD_ID;
        endcase
        add_report(make_report(KIND_FINISH, message_id, status, '0, '0, 1'b0));
        stream_phase = PH_LEN;
    endtask

    // Advance the software deframer by one accepted beat and queue its reports
    task automatic deframe_beat(input logic cmd, input logic [7:0] rx,
                                input logic [PIECE_W-1:0] query);
        logic [31:0] base;
        logic [31:0] idx;
        logic [7:0]  fresh;
        t_res        tail;
        if (cmd) begin
            add_report(make_report(KIND_QUERY, 8'd0, ST_OK, '0, '0,
                                   known_pieces[query]));
        end else if (stream_phase == PH_ID) begin
            message_id   = rx;
            payload_left = length_word - 32'd1;
            payload_pos  = '0;
            have_index   = '0;
            if (payload_left == 0) close_message();
            else stream_phase = PH_PAYLOAD;
        end else if (stream_phase == PH_PAYLOAD) begin
            if (message_id == MSG_BITFIELD && payload_pos < MAP_BYTES) begin
                // Byte p covers pieces 8p..8p+7, most significant bit first
                base  = payload_pos * 8;
                fresh = '0;
                for (int k = 0; k < 8; k++) begin
                    idx = base + k;
                    if (rx[7-k] && idx < piece_bound()
                            && !known_pieces[idx[PIECE_W-1:0]]) begin
                        known_pieces[idx[PIECE_W-1:0]] = 1'b1;
                        fresh[k]                       = 1'b1;
                    end
                end
                if (fresh != '0)
                    add_report(make_report(KIND_AVAIL, 8'd0, ST_OK,
                                           base[PIECE_W-1:0], fresh, 1'b0));
            end else if (message_id == MSG_HAVE && payload_pos < HAVE_IDX_BYTES) begin
                have_index = {have_index[23:0], rx};
            end
            payload_pos  = payload_pos + 32'd1;
            payload_left = payload_left - 32'd1;
            if (payload_left == 0) close_message();
        end else begin
            // Length prefix, big-endian; the spare phase behaves the same
            stream_phase = PH_LEN;
            length_word  = {length_word[23:0], rx};
            header_bytes = header_bytes + 3'd1;
            if (header_bytes >= 3'd4) begin
                header_bytes = '0;
                if (length_word == 0)
                    add_report(make_report(KIND_FINISH, 8'd0, ST_KEEPALIVE,
                                           '0, '0, 1'b0));
                else
                    stream_phase = PH_ID;
            end
        end
        // Mark the closing report of this beat, then hand them all on
        if (beat_reports.size() != 0) begin
            tail      = beat_reports.pop_back();
            tail.last = 1'b1;
            add_report(tail);
        end
        foreach (beat_reports[i])
            pending_reports.insert(pending_reports.size(), beat_reports[i]);
        beat_reports.delete();
    endtask

    // ------------------------------------------------------------------------
    // Result side: stall on a pattern of its own and check every beat taken
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        stall_step <= stall_step + 9'd1;
        case (stall_step[8:7])
            2'd0:    pop <= 1'b1;                          // no stalls at all
            2'd1:    pop <= ($urandom_range(3) != 0);      // light stalls
            2'd2:    pop <= ($urandom_range(5) == 0);      // heavy stalls
            default: pop <= (stall_step[3:0] == 4'd0);     // heaviest stalls
        endcase
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : report_check
        t_res want;
        if (i_rst_n && pop && !empty) begin
            if (pending_reports.size() == 0) begin
                $error("result beat with nothing owed: kind %0d id %0d", o_kind, o_message_id);
                error_count++;
            end else begin
                want = pending_reports.pop_front();
                compare_field("kind", 32'(want.kind), 32'(o_kind));
                compare_field("message_id", 32'(want.message_id), 32'(o_message_id));
                compare_field("msg_status", 32'(want.status), 32'(o_msg_status));
                compare_field("avail_base", 32'(want.avail_base), 32'(o_avail_base));
                compare_field("avail_mask", 32'(want.avail_mask), 32'(o_avail_mask));
                compare_field("piece_available", 32'(want.piece_available),
                              32'(o_piece_available));
                compare_field("peer_choking_now", 32'(want.choke),
                              32'(o_peer_choking_now));
                compare_field("peer_interested_now", 32'(want.interest),
                              32'(o_peer_interested_now));
                compare_field("last", 32'(want.last), 32'(o_last));
            end
        end
    end

    // Watchdog: a hung core or a missing result ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $error("timed out after %0d cycles, %0d results still owed",
                   cycle_count, pending_reports.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Close a burst with a random gap; bursts are mostly short, now and then long
    task automatic pace_sender();
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 4);
        end
    endtask

    // Offer one beat and hold it until the core takes it
    task automatic send_beat(input logic cmd, input logic [7:0] rx,
                             input logic [PIECE_W-1:0] query);
        push          <= 1'b1;
        i_cmd         <= cmd;
        i_rx_byte     <= rx;
        i_query_index <= query;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        deframe_beat(cmd, rx, query);
        beats_sent++;
        pace_sender();
    endtask

    task automatic send_query(input logic [PIECE_W-1:0] query);
        send_beat(1'b1, 8'($urandom), query);
    endtask

    // Stream the framed bytes, dropping in queries at the current rate
    task automatic send_frame();
        logic [31:0] bound;
        foreach (frame[i]) begin
            if ($urandom_range(99) < query_pct) begin
                bound = piece_bound();
                send_query((bound != 0 && $urandom_range(1) == 0)
                           ? PIECE_W'($urandom_range(bound - 1)) : PIECE_W'($urandom));
            end
            send_beat(1'b0, frame[i], PIECE_W'($urandom));
        end
        frame.delete();
    endtask

    task automatic push_length(input logic [31:0] len);
        add_byte(len[31:24]);
        add_byte(len[23:16]);
        add_byte(len[15:8]);
        add_byte(len[7:0]);
    endtask

    task automatic send_keepalive();
        push_length(32'd0);
        send_frame();
    endtask

    // Frame one message; payload bytes come from the payload queue, then random
    task automatic send_message(input logic [7:0] id, input int unsigned pay_len);
        push_length(pay_len + 1);
        add_byte(id);
        for (int i = 0; i < pay_len; i++)
            add_byte((i < payload.size()) ? payload[i] : 8'($urandom));
        payload.delete();
        send_frame();
    endtask

    task automatic send_have(input logic [31:0] index, input int unsigned pay_len);
        payload = '{index[31:24], index[23:16], index[15:8], index[7:0]};
        send_message(MSG_HAVE, pay_len);
    endtask

    task automatic write_piece_count(input logic [COUNT_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        piece_count = value;
    endtask

    // Hold the input until every owed result has come, then let the core settle
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (IDLE_TAIL) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Keep-alive, every flag message, the skipped ids and invalid ids
    task automatic test_flags_and_ids();
        query_pct = 0;
        send_keepalive();
        send_message(MSG_UNCHOKE, 0);
        send_message(MSG_INTERESTED, 0);
        send_message(MSG_CHOKE, 0);
        send_message(MSG_NOT_INTERESTED, 0);
        send_message(MSG_UNCHOKE, 2);           // flags still act with a payload
        send_message(MSG_INTERESTED, 0);
        send_message(MSG_REQUEST, 2);
        send_message(MSG_PIECE, 0);
        send_message(MSG_CANCEL, 1);
        send_message(MSG_PORT, 2);
        send_message(8'd10, 0);                 // first invalid id
        send_message(8'hFF, 1);
        send_keepalive();
    endtask

    // Bitfield and have updates against a small piece count
    task automatic test_map_updates();
        query_pct = 0;
        send_query(12'd0);
        // Third byte straddles the limit of 20; fourth lies wholly beyond it
        payload = '{8'hFF, 8'h0F, 8'hFF, 8'h81};
        send_message(MSG_BITFIELD, 4);
        send_query(12'd19);
        send_query(12'd20);
        send_have(32'd20, 4);                   // at the limit: ignored
        send_have(32'd9, 4);                    // new piece
        send_have(32'd9, 4);                    // already known
        send_have(32'd10, 3);                   // short payload
        send_have(32'd10, 6);                   // long payload
        send_have(32'h0100_000A, 4);            // index far out of range
        send_message(MSG_HAVE, 0);
        payload = '{8'hC0, 8'h40};
        send_message(MSG_BITFIELD, 2);          // repeated bitfield
        send_message(MSG_BITFIELD, 0);
        send_query(12'd8);
        send_query(12'd10);
        send_query(12'd4095);
    endtask

    // Piece count at both ends of its range
    task automatic test_piece_count_extremes();
        query_pct = 0;
        wait_idle();
        write_piece_count('0);
        payload = '{8'hFF};
        send_message(MSG_BITFIELD, 1);
        send_have(32'd30, 4);
        send_query(12'd30);
        send_query(12'd0);
        wait_idle();
        write_piece_count(COUNT_W'(MAX_PIECES));
        send_message(MSG_BITFIELD, 6);
        send_have(32'(MAX_PIECES - 1), 4);
        send_query(12'd4095);
        send_query(12'd4088);
    endtask

    // One message of random type and content, mostly well formed
    task automatic send_random_message();
        int unsigned pick;
        int unsigned span;
        logic [31:0] bound;
        logic [31:0] index;
        pick  = $urandom_range(99);
        bound = piece_bound();
        if (pick < 8) begin
            send_keepalive();
        end else if (pick < 30) begin
            send_message(8'($urandom_range(3)),
                         ($urandom_range(7) == 0) ? $urandom_range(1, 3) : 0);
        end else if (pick < 55) begin
            index = (bound != 0 && $urandom_range(3) != 0) ? $urandom_range(bound - 1)
                                                           : $urandom;
            send_have(index, ($urandom_range(4) == 0) ? $urandom_range(0, 7) : 4);
        end else if (pick < 75) begin
            span = (bound + 7) / 8 + 2;
            send_message(MSG_BITFIELD, $urandom_range(0, (span > 10) ? 10 : span));
        end else if (pick < 88) begin
            send_message(8'($urandom_range(6, 9)), $urandom_range(0, 6));
        end else begin
            send_message(8'($urandom_range(10, 255)), $urandom_range(0, 4));
        end
    endtask

    // Random traffic in phases, each under its own piece count and query rate
    task automatic test_random_traffic();
        int unsigned target;
        for (int phase = 0; phase < 4; phase++) begin
            wait_idle();
            case (phase)
                0:       begin write_piece_count(13'd9);                        query_pct = 10; end
                1:       begin write_piece_count(COUNT_W'($urandom_range(1, 4095))); query_pct = 10; end
                2:       begin write_piece_count(COUNT_W'(MAX_PIECES));         query_pct = 25; end
                default: begin write_piece_count(COUNT_W'($urandom_range(0, 64))); query_pct = 5; end
            endcase
            target = beats_sent + 45;
            while (beats_sent < target) send_random_message();
        end
    endtask

    initial begin
        push          <= 1'b0;
        i_cmd         <= 1'b0;
        i_rx_byte     <= '0;
        i_query_index <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        i_rst_n       <= 1'b0;
        foreach (known_pieces[i]) known_pieces[i] = 1'b0;
        repeat (RESET_TICKS) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // The core sweeps its map clear after reset and holds full meanwhile
        write_piece_count(13'd20);

        test_flags_and_ids();
        test_map_updates();
        test_piece_count_extremes();
        test_random_traffic();

        wait_idle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/pwmd_pkg.sv
hw/rtl/pwmd_front.sv
hw/rtl/pwmd_opq.sv
hw/rtl/pwmd_back.sv
hw/rtl/peer_wire_message_deframer_core.sv
tb/testbench.sv
